FILE: rtl/matrix_inverse_3x3_top_macros.svh
// Assertion macros for the matrix inverse block
`ifndef MATRIX_INVERSE_3X3_TOP_MACROS_SVH
`define MATRIX_INVERSE_3X3_TOP_MACROS_SVH
// Check that an implication holds at every clock edge outside reset
`define MI_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Check that a condition is followed by another in the next cycle
`define MI_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

FILE: rtl/minv_pkg.sv
// Shared types and constants for the matrix inverse block
package minv_pkg;
	localparam int ElemWidth = 16;
	localparam int OutWidth = 32;
	localparam int QShift = 28;
	localparam int CofWidth = 2 * ElemWidth + 1;
	localparam int DetWidth = 3 * ElemWidth + 2;
	localparam int NumWidth = CofWidth - 1 + QShift;
	localparam int MagWidth = DetWidth - 1;
	localparam int QuoWidth = NumWidth;
	localparam int DivSteps = QuoWidth;
	localparam int BitsPerStage = 4;
	localparam int DivStages = (DivSteps + BitsPerStage - 1) / BitsPerStage;

	typedef logic signed [ElemWidth-1:0] elem_t;
	typedef logic signed [CofWidth-1:0] cof_t;
	typedef logic signed [DetWidth-1:0] det_t;

	// Sideband that travels alongside each matrix
	typedef struct packed {
		logic singular;
		logic det_neg;
	} side_t;
endpackage

FILE: rtl/matrix_inverse_3x3_top.sv
// Top level: 3x3 matrix inverse by adjugate, fully pipelined
//
// channel | direction | handshake        | payload
// input   | in        | start / busy     | in_r0c0 .. in_r2c2, Q4.12
// result  | out       | done strobe      | inv_r0c0 .. inv_r2c2 Q16.16, singular, saturated
//
// One matrix enters each cycle; busy is held low.
// The pipeline from the start beat to done is 4 cofactor/determinant
// stages, 1 sign stage, the divider (DivStages = 15 stages of 4 quotient
// bits each) and 1 saturation stage.
// Reset clears the valid bits only. done cannot be held off.
`include "matrix_inverse_3x3_top_macros.svh"
module matrix_inverse_3x3_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [minv_pkg::ElemWidth-1:0] in_r0c0,
	input logic [minv_pkg::ElemWidth-1:0] in_r1c0,
	input logic [minv_pkg::ElemWidth-1:0] in_r2c0,
	input logic [minv_pkg::ElemWidth-1:0] in_r0c1,
	input logic [minv_pkg::ElemWidth-1:0] in_r1c1,
	input logic [minv_pkg::ElemWidth-1:0] in_r2c1,
	input logic [minv_pkg::ElemWidth-1:0] in_r0c2,
	input logic [minv_pkg::ElemWidth-1:0] in_r1c2,
	input logic [minv_pkg::ElemWidth-1:0] in_r2c2,
	output logic done,
	output logic [minv_pkg::OutWidth-1:0] inv_r0c0,
	output logic [minv_pkg::OutWidth-1:0] inv_r1c0,
	output logic [minv_pkg::OutWidth-1:0] inv_r2c0,
	output logic [minv_pkg::OutWidth-1:0] inv_r0c1,
	output logic [minv_pkg::OutWidth-1:0] inv_r1c1,
	output logic [minv_pkg::OutWidth-1:0] inv_r2c1,
	output logic [minv_pkg::OutWidth-1:0] inv_r0c2,
	output logic [minv_pkg::OutWidth-1:0] inv_r1c2,
	output logic [minv_pkg::OutWidth-1:0] inv_r2c2,
	output logic singular,
	output logic saturated
);
	localparam int NS = minv_pkg::DivStages;
	localparam int OW = minv_pkg::OutWidth;
	localparam int QW = minv_pkg::QuoWidth;
	localparam int CW = minv_pkg::CofWidth;

	minv_pkg::elem_t e [9];
	minv_pkg::cof_t cof [9];
	minv_pkg::det_t det;
	logic cv;
	logic [8:0] cneg_s5;
	logic [minv_pkg::NumWidth-1:0] num_s5 [9];
	logic [minv_pkg::MagWidth-1:0] dmag_s5;
	minv_pkg::side_t side_s5;
	logic v_s5;
	logic dv [9];
	logic [QW-1:0] quo [9];
	minv_pkg::side_t side_d [NS+1];
	logic [8:0] neg_d [NS+1];
	logic [OW-1:0] inv_q [9];
	logic sing_q, sat_q, done_q;

	assign busy = 1'b0;
	assign e = '{in_r0c0, in_r1c0, in_r2c0, in_r0c1, in_r1c1, in_r2c1,
		in_r0c2, in_r1c2, in_r2c2};

	minv_cofactor u_cof (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .e(e),
		.out_valid(cv), .cof(cof), .det(det)
	);

	// take magnitudes and signs ahead of the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= cv;
		end
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			logic [CW-1:0] m;
			m = cof[k][CW-1] ? CW'(-cof[k]) : cof[k];
			num_s5[k] <= {m[CW-2:0], {minv_pkg::QShift{1'b0}}};
			cneg_s5[k] <= cof[k][CW-1] ^ det[minv_pkg::DetWidth-1];
		end
		dmag_s5 <= det[minv_pkg::DetWidth-1] ?
			minv_pkg::MagWidth'(-det) : minv_pkg::MagWidth'(det);
		side_s5.singular <= (det == '0);
		side_s5.det_neg <= det[minv_pkg::DetWidth-1];
	end

	for (genvar k = 0; k < 9; k++) begin : g_div
		minv_divider u_div (
			.clk(clk), .arst_n(arst_n), .in_valid(v_s5),
			.num(num_s5[k]), .den(dmag_s5 == '0 ? minv_pkg::MagWidth'(1) : dmag_s5),
			.out_valid(dv[k]), .quo(quo[k])
		);
	end

	// carry signs and the singular mark alongside the divider
	assign side_d[0] = side_s5;
	assign neg_d[0] = cneg_s5;
	for (genvar g = 0; g < NS; g++) begin : g_side
		always_ff @(posedge clk) begin
			side_d[g+1] <= side_d[g];
			neg_d[g+1] <= neg_d[g];
		end
	end

	// saturate, apply sign, zero on singular
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv[0];
		end
	end
	always_ff @(posedge clk) begin
		logic s;
		logic big;
		logic [OW-1:0] v;
		s = 1'b0;
		for (int k = 0; k < 9; k++) begin
			if (neg_d[NS][k]) begin
				big = (quo[k][QW-1:OW-1] != '0) && (quo[k] != (QW'(1) << (OW - 1)));
				v = big ? {1'b1, {(OW-1){1'b0}}} : OW'(-quo[k]);
			end else begin
				big = (quo[k][QW-1:OW-1] != '0);
				v = big ? {1'b0, {(OW-1){1'b1}}} : quo[k][OW-1:0];
			end
			s = s | big;
			inv_q[k] <= side_d[NS].singular ? '0 : v;
		end
		sat_q <= s & ~side_d[NS].singular;
		sing_q <= side_d[NS].singular;
	end

	assign done = done_q;
	assign inv_r0c0 = inv_q[0];
	assign inv_r1c0 = inv_q[1];
	assign inv_r2c0 = inv_q[2];
	assign inv_r0c1 = inv_q[3];
	assign inv_r1c1 = inv_q[4];
	assign inv_r2c1 = inv_q[5];
	assign inv_r0c2 = inv_q[6];
	assign inv_r1c2 = inv_q[7];
	assign inv_r2c2 = inv_q[8];
	assign singular = sing_q;
	assign saturated = sat_q;

	`MI_ASSERT_IMP(a_sing_zero, clk, arst_n, done && singular, inv_r0c0 == '0 && !saturated, "singular result not zero")
	`MI_ASSERT_NEXT(a_div_done, clk, arst_n, dv[0], done, "divider beat lost")
	`MI_ASSERT_IMP(a_lanes, clk, arst_n, 1'b1, dv[0] == dv[8], "divider lanes out of step")
endmodule

FILE: rtl/minv_cofactor.sv
// Cofactor and determinant stages: products, differences, expansion
module minv_cofactor (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input minv_pkg::elem_t e [9],
	output logic out_valid,
	output minv_pkg::cof_t cof [9],
	output minv_pkg::det_t det
);
	localparam int PW = 2 * minv_pkg::ElemWidth;

	logic signed [PW-1:0] pa_s1 [9];
	logic signed [PW-1:0] pb_s1 [9];
	minv_pkg::elem_t e0_s1, e3_s1, e6_s1;
	minv_pkg::elem_t e0_s2, e3_s2, e6_s2;
	minv_pkg::cof_t cof_s2 [9];
	logic signed [minv_pkg::DetWidth-1:0] t_s3 [3];
	minv_pkg::cof_t cof_s3 [9];
	minv_pkg::det_t det_s4;
	minv_pkg::cof_t cof_s4 [9];
	logic v_s1, v_s2, v_s3, v_s4;

	// operand index table per cofactor
	function automatic int idx(input int k, input int j);
		int t [9][4];
		t = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
			'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
			'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
		return t[k][j];
	endfunction

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// form products, then cofactors, then first-row terms, then the sum
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			pa_s1[k] <= e[idx(k, 0)] * e[idx(k, 1)];
			pb_s1[k] <= e[idx(k, 2)] * e[idx(k, 3)];
			cof_s2[k] <= minv_pkg::CofWidth'(pa_s1[k]) - minv_pkg::CofWidth'(pb_s1[k]);
		end
		e0_s1 <= e[0];
		e3_s1 <= e[3];
		e6_s1 <= e[6];
		e0_s2 <= e0_s1;
		e3_s2 <= e3_s1;
		e6_s2 <= e6_s1;
		t_s3[0] <= minv_pkg::DetWidth'(e0_s2 * cof_s2[0]);
		t_s3[1] <= minv_pkg::DetWidth'(e3_s2 * cof_s2[1]);
		t_s3[2] <= minv_pkg::DetWidth'(e6_s2 * cof_s2[2]);
		cof_s3 <= cof_s2;
		det_s4 <= t_s3[0] + t_s3[1] + t_s3[2];
		cof_s4 <= cof_s3;
	end

	assign out_valid = v_s4;
	assign cof = cof_s4;
	assign det = det_s4;
endmodule

FILE: rtl/minv_divider.sv
// Pipelined restoring divider: one unsigned quotient per cycle per lane
module minv_divider (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [minv_pkg::NumWidth-1:0] num,
	input logic [minv_pkg::MagWidth-1:0] den,
	output logic out_valid,
	output logic [minv_pkg::QuoWidth-1:0] quo
);
	localparam int NS = minv_pkg::DivStages;
	localparam int NW = minv_pkg::NumWidth;
	localparam int DW = minv_pkg::MagWidth;
	localparam int BP = minv_pkg::BitsPerStage;

	logic [NW-1:0] n_s [NS+1];
	logic [DW:0] r_s [NS+1];
	logic [DW-1:0] d_s [NS+1];
	logic v_s [NS+1];

	assign n_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;
	assign v_s[0] = in_valid;

	// each stage retires BP quotient bits, shifting them into the numerator word
	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [NW-1:0] n_nx;
		logic [DW:0] r_nx;
		always_comb begin
			logic [DW+1:0] t;
			n_nx = n_s[g];
			r_nx = r_s[g];
			for (int b = 0; b < BP; b++) begin
				if (g * BP + b < NW) begin
					t = {r_nx, n_nx[NW-1]};
					n_nx = {n_nx[NW-2:0], 1'b0};
					if (t >= {1'b0, 1'b0, d_s[g]}) begin
						t = t - {2'b00, d_s[g]};
						n_nx[0] = 1'b1;
					end
					r_nx = t[DW:0];
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			n_s[g+1] <= n_nx;
			r_s[g+1] <= r_nx;
			d_s[g+1] <= d_s[g];
		end
	end

	assign out_valid = v_s[NS];
	assign quo = n_s[NS];
endmodule
